@@ rtl/core/gdwc_pkg.sv @@
package gdwc_pkg;

    localparam int DEF_MAX_RULES       = 1024;
    localparam int DEF_MAX_WORDS       = 4096;
    localparam int DEF_MAX_EDGES       = 8192;
    localparam int DEF_MAX_OCCURRENCES = 16384;
    localparam int DEF_COUNT_WIDTH     = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int NUM_WORDS_W = 13;
    localparam int NUM_RULES_W = 11;
    localparam logic [NUM_WORDS_W-1:0] RST_NUM_WORDS = 13'd4096;
    localparam logic [NUM_RULES_W-1:0] RST_NUM_RULES = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RULES = 2'd1;

    localparam int TOTAL_W = 48;

    typedef enum logic [2:0] {
        OP_EDGE  = 3'd0,
        OP_OCC   = 3'd1,
        OP_RUN   = 3'd2,
        OP_QUERY = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_SAT   = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SW_RESET = 2'd0,
        SW_CLEAR = 2'd1,
        SW_RUN   = 2'd2
    } t_sweep;

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_LD_EDGE,
        S_LD_OCC,
        S_QUERY,
        S_R_INIT,
        S_R_POP,
        S_R_POP1,
        S_R_EHEAD,
        S_R_EDGE,
        S_R_EDGE1,
        S_O_RULE,
        S_O_RULE1,
        S_O_WALK,
        S_O_WALK1,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ACC
    } t_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  parent_rule;
        logic [11:0] child_id;
        logic [15:0] freq;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [TOTAL_W-1:0] word_total;
    } t_out_item;

endpackage

@@ rtl/core/grammar_dag_word_count.sv @@
// Load edge / occurrence: through S_LD_EDGE / S_LD_OCC to result; query: through S_QUERY;
// bad or unknown item: answered from S_IDLE. Clear: one sweep over the rule and word stores.
// Run: a sweep of weights, seen counts and word totals only, then the ready queue of rules and
// their edges, then each rule below num_rules and its occurrences; every edge and occurrence goes
// via one shared HW x 16-bit multiplier in two halves, then a saturating add into its store.
// One item at a time; the next is taken once the result register has been read.
// Reset (sync, active low) starts the same sweep; no item is taken until it ends.
module grammar_dag_word_count #(
    parameter int MAX_RULES       = gdwc_pkg::DEF_MAX_RULES,
    parameter int MAX_WORDS       = gdwc_pkg::DEF_MAX_WORDS,
    parameter int MAX_EDGES       = gdwc_pkg::DEF_MAX_EDGES,
    parameter int MAX_OCCURRENCES = gdwc_pkg::DEF_MAX_OCCURRENCES,
    parameter int COUNT_WIDTH     = gdwc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  gdwc_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output gdwc_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gdwc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gdwc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW   = COUNT_WIDTH;
    localparam int RW   = $clog2(MAX_RULES);
    localparam int RCW  = $clog2(MAX_RULES + 1);
    localparam int WIW  = $clog2(MAX_WORDS);
    localparam int WCW  = $clog2(MAX_WORDS + 1);
    localparam int EPW  = $clog2(MAX_EDGES + 1);
    localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int OPW  = $clog2(MAX_OCCURRENCES + 1);
    localparam int OIW  = (MAX_OCCURRENCES > 1) ? $clog2(MAX_OCCURRENCES) : 1;
    localparam int QN   = MAX_RULES + 1;
    localparam int QIW  = $clog2(QN);
    localparam int QCW  = $clog2(QN + 1);
    localparam int SWN  = (MAX_RULES > MAX_WORDS) ? MAX_RULES : MAX_WORDS;
    localparam int SWW  = $clog2(SWN);
    localparam int HW   = (CW + 1) / 2;
    localparam int HIW  = CW - HW;
    localparam int MPW  = HW + 16;
    localparam int PW   = CW + 17;
    localparam int EDW  = RW + 16 + EPW;
    localparam int ODW  = WIW + 16 + OPW;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // ---------------- registers ----------------
    gdwc_pkg::t_state    r_state,     n_state;
    gdwc_pkg::t_sweep    r_sw_mode,   n_sw_mode;
    logic [SWW-1:0]      r_sweep,     n_sweep;
    logic [EPW-1:0]      r_edge_fill, n_edge_fill;
    logic [OPW-1:0]      r_occ_fill,  n_occ_fill;
    logic                r_sat,       n_sat;
    logic [QCW-1:0]      r_qhead,     n_qhead;
    logic [QCW-1:0]      r_qtail,     n_qtail;
    logic                r_out_valid, n_out_valid;
    logic [gdwc_pkg::NUM_WORDS_W-1:0] r_num_words;
    logic [gdwc_pkg::NUM_RULES_W-1:0] r_num_rules;

    gdwc_pkg::t_in_item  r_item,      n_item;
    gdwc_pkg::t_out_item r_out_item,  n_out_item;
    logic [RW-1:0]       r_cur,       n_cur;
    logic [RW-1:0]       r_child,     n_child;
    logic [WIW-1:0]      r_word,      n_word;
    logic [15:0]         r_rep,       n_rep;
    logic [EPW-1:0]      r_eptr,      n_eptr;
    logic [OPW-1:0]      r_optr,      n_optr;
    logic [RCW-1:0]      r_rule,      n_rule;
    logic [CW-1:0]       r_rw,        n_rw;
    logic [CW-1:0]       r_mul_a,     n_mul_a;
    logic [MPW-1:0]      r_plo,       n_plo;
    logic [MPW-1:0]      r_phi,       n_phi;
    logic [CW-1:0]       r_prod,      n_prod;
    logic                r_acc_occ,   n_acc_occ;

    // ---------------- memories ----------------
    logic [CW-1:0]  m_weight [MAX_RULES];
    logic [EPW-1:0] m_etot   [MAX_RULES];
    logic [EPW-1:0] m_eseen  [MAX_RULES];
    logic [EPW-1:0] m_ehead  [MAX_RULES];
    logic [OPW-1:0] m_ohead  [MAX_RULES];
    logic [EDW-1:0] m_edge   [MAX_EDGES];
    logic [ODW-1:0] m_occ    [MAX_OCCURRENCES];
    logic [CW-1:0]  m_word   [MAX_WORDS];
    logic [RW-1:0]  m_queue  [QN];

    logic           weight_we, etot_we, eseen_we, ehead_we, ohead_we;
    logic           edge_we, occ_we, word_we, queue_we;
    logic [RW-1:0]  weight_ra, weight_wa, etot_ra, etot_wa, eseen_ra, eseen_wa;
    logic [RW-1:0]  ehead_ra, ehead_wa, ohead_ra, ohead_wa;
    logic [EIW-1:0] edge_ra, edge_wa;
    logic [OIW-1:0] occ_ra, occ_wa;
    logic [WIW-1:0] word_ra, word_wa;
    logic [QIW-1:0] queue_ra, queue_wa;
    logic [CW-1:0]  weight_wd, weight_rd, word_wd, word_rd;
    logic [EPW-1:0] etot_wd, etot_rd, eseen_wd, eseen_rd, ehead_wd, ehead_rd;
    logic [OPW-1:0] ohead_wd, ohead_rd;
    logic [EDW-1:0] edge_wd, edge_rd;
    logic [ODW-1:0] occ_wd, occ_rd;
    logic [RW-1:0]  queue_wd, queue_rd;

    always_ff @(posedge i_clk) begin
        if (weight_we) m_weight[weight_wa] <= weight_wd;
        weight_rd <= m_weight[weight_ra];
    end
    always_ff @(posedge i_clk) begin
        if (etot_we) m_etot[etot_wa] <= etot_wd;
        etot_rd <= m_etot[etot_ra];
    end
    always_ff @(posedge i_clk) begin
        if (eseen_we) m_eseen[eseen_wa] <= eseen_wd;
        eseen_rd <= m_eseen[eseen_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ehead_we) m_ehead[ehead_wa] <= ehead_wd;
        ehead_rd <= m_ehead[ehead_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ohead_we) m_ohead[ohead_wa] <= ohead_wd;
        ohead_rd <= m_ohead[ohead_ra];
    end
    always_ff @(posedge i_clk) begin
        if (edge_we) m_edge[edge_wa] <= edge_wd;
        edge_rd <= m_edge[edge_ra];
    end
    always_ff @(posedge i_clk) begin
        if (occ_we) m_occ[occ_wa] <= occ_wd;
        occ_rd <= m_occ[occ_ra];
    end
    always_ff @(posedge i_clk) begin
        if (word_we) m_word[word_wa] <= word_wd;
        word_rd <= m_word[word_ra];
    end
    always_ff @(posedge i_clk) begin
        if (queue_we) m_queue[queue_wa] <= queue_wd;
        queue_rd <= m_queue[queue_ra];
    end

    // ---------------- shared datapath ----------------
    logic [RCW-1:0] eff_rules;
    logic [WCW-1:0] eff_words;
    logic [HW-1:0]  mul_x;
    logic [MPW-1:0] mul_p;
    logic [PW-1:0]  prod_full;
    logic           prod_ovf;
    logic [CW-1:0]  acc_src;
    logic [CW:0]    acc_sum;
    logic [EPW-1:0] seen_inc;
    logic           sw_rule, sw_word, sweep_last;
    logic           edge_bad, occ_bad, qry_bad;
    logic           fin;
    gdwc_pkg::t_status fin_status;
    logic [gdwc_pkg::TOTAL_W-1:0] fin_total;
    gdwc_pkg::t_status run_status;

    assign eff_rules = (32'(r_num_rules) < 32'(MAX_RULES)) ? RCW'(r_num_rules)
                                                          : RCW'(MAX_RULES);
    assign eff_words = (32'(r_num_words) < 32'(MAX_WORDS)) ? WCW'(r_num_words)
                                                          : WCW'(MAX_WORDS);

    // one HW x 16-bit multiplier, used for the low then the high half of the weight
    assign mul_x = (r_state == gdwc_pkg::S_MUL0) ? r_mul_a[HW-1:0] : HW'(r_mul_a[CW-1:HW]);
    assign mul_p = MPW'(mul_x) * MPW'(r_rep);
    assign prod_full = PW'({r_phi, {HW{1'b0}}}) + PW'(r_plo);
    assign prod_ovf  = |prod_full[PW-1:CW];

    assign acc_src  = r_acc_occ ? word_rd : weight_rd;
    assign acc_sum  = {1'b0, acc_src} + {1'b0, r_prod};
    assign seen_inc = eseen_rd + EPW'(1);

    assign sw_rule    = 32'(r_sweep) < 32'(MAX_RULES);
    assign sw_word    = 32'(r_sweep) < 32'(MAX_WORDS);
    assign sweep_last = 32'(r_sweep) == 32'(SWN - 1);

    assign edge_bad = !(32'(i_in_item.parent_rule) < 32'(eff_rules)) ||
                      !(32'(i_in_item.child_id) < 32'(eff_rules));
    assign occ_bad  = !(32'(i_in_item.parent_rule) < 32'(eff_rules)) ||
                      !(32'(i_in_item.child_id) < 32'(eff_words));
    assign qry_bad  = !(32'(i_in_item.child_id) < 32'(eff_words));
    assign run_status = r_sat ? gdwc_pkg::STS_SAT : gdwc_pkg::STS_OK;

    always_comb begin
        n_state     = r_state;
        n_sw_mode   = r_sw_mode;
        n_sweep     = r_sweep;
        n_edge_fill = r_edge_fill;
        n_occ_fill  = r_occ_fill;
        n_sat       = r_sat;
        n_qhead     = r_qhead;
        n_qtail     = r_qtail;
        n_out_valid = r_out_valid;
        n_item      = r_item;
        n_out_item  = r_out_item;
        n_cur       = r_cur;
        n_child     = r_child;
        n_word      = r_word;
        n_rep       = r_rep;
        n_eptr      = r_eptr;
        n_optr      = r_optr;
        n_rule      = r_rule;
        n_rw        = r_rw;
        n_mul_a     = r_mul_a;
        n_plo       = r_plo;
        n_phi       = r_phi;
        n_prod      = r_prod;
        n_acc_occ   = r_acc_occ;

        weight_we = 1'b0; weight_ra = r_cur;   weight_wa = r_child; weight_wd = '0;
        etot_we   = 1'b0; etot_ra   = r_child; etot_wa   = r_child; etot_wd   = '0;
        eseen_we  = 1'b0; eseen_ra  = r_child; eseen_wa  = r_child; eseen_wd  = '0;
        ehead_we  = 1'b0; ehead_ra  = r_cur;   ehead_wa  = r_cur;   ehead_wd  = '0;
        ohead_we  = 1'b0; ohead_ra  = r_cur;   ohead_wa  = r_cur;   ohead_wd  = '0;
        edge_we   = 1'b0; edge_ra   = EIW'(r_eptr - EPW'(1));
        edge_wa   = EIW'(r_edge_fill);  edge_wd = '0;
        occ_we    = 1'b0; occ_ra    = OIW'(r_optr - OPW'(1));
        occ_wa    = OIW'(r_occ_fill);   occ_wd  = '0;
        word_we   = 1'b0; word_ra   = r_word;  word_wa   = r_word;  word_wd   = '0;
        queue_we  = 1'b0; queue_ra  = r_qhead[QIW-1:0];
        queue_wa  = r_qtail[QIW-1:0];   queue_wd = r_child;

        o_in_ready = 1'b0;
        fin        = 1'b0;
        fin_status = gdwc_pkg::STS_OK;
        fin_total  = '0;

        case (r_state)
            gdwc_pkg::S_SWEEP: begin
                weight_we = sw_rule; weight_wa = r_sweep[RW-1:0];
                eseen_we  = sw_rule; eseen_wa  = r_sweep[RW-1:0];
                word_we   = sw_word; word_wa   = r_sweep[WIW-1:0];
                etot_wa   = r_sweep[RW-1:0];
                ehead_wa  = r_sweep[RW-1:0];
                ohead_wa  = r_sweep[RW-1:0];
                if (r_sw_mode != gdwc_pkg::SW_RUN) begin
                    etot_we  = sw_rule;
                    ehead_we = sw_rule;
                    ohead_we = sw_rule;
                end
                n_sweep = r_sweep + SWW'(1);
                if (sweep_last) begin
                    n_sweep = '0;
                    case (r_sw_mode)
                        gdwc_pkg::SW_RUN: begin
                            n_state = gdwc_pkg::S_R_INIT;
                        end
                        gdwc_pkg::SW_CLEAR: begin
                            n_edge_fill = '0;
                            n_occ_fill  = '0;
                            n_sat       = 1'b0;
                            fin         = 1'b1;
                        end
                        default: begin
                            n_edge_fill = '0;
                            n_occ_fill  = '0;
                            n_sat       = 1'b0;
                            n_state     = gdwc_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            gdwc_pkg::S_IDLE: begin
                o_in_ready = !r_out_valid;
                if (i_in_valid && !r_out_valid) begin
                    n_item = i_in_item;
                    case (i_in_item.op)
                        gdwc_pkg::OP_EDGE: begin
                            if (edge_bad) begin
                                fin = 1'b1; fin_status = gdwc_pkg::STS_RANGE;
                            end else if (32'(r_edge_fill) >= 32'(MAX_EDGES)) begin
                                fin = 1'b1; fin_status = gdwc_pkg::STS_FULL;
                            end else begin
                                ehead_ra = RW'(i_in_item.parent_rule);
                                etot_ra  = RW'(i_in_item.child_id);
                                n_state  = gdwc_pkg::S_LD_EDGE;
                            end
                        end
                        gdwc_pkg::OP_OCC: begin
                            if (occ_bad) begin
                                fin = 1'b1; fin_status = gdwc_pkg::STS_RANGE;
                            end else if (32'(r_occ_fill) >= 32'(MAX_OCCURRENCES)) begin
                                fin = 1'b1; fin_status = gdwc_pkg::STS_FULL;
                            end else begin
                                ohead_ra = RW'(i_in_item.parent_rule);
                                n_state  = gdwc_pkg::S_LD_OCC;
                            end
                        end
                        gdwc_pkg::OP_RUN: begin
                            n_sat     = 1'b0;
                            n_sw_mode = gdwc_pkg::SW_RUN;
                            n_sweep   = '0;
                            n_state   = gdwc_pkg::S_SWEEP;
                        end
                        gdwc_pkg::OP_QUERY: begin
                            if (qry_bad) begin
                                fin = 1'b1; fin_status = gdwc_pkg::STS_RANGE;
                            end else begin
                                word_ra = WIW'(i_in_item.child_id);
                                n_state = gdwc_pkg::S_QUERY;
                            end
                        end
                        gdwc_pkg::OP_CLEAR: begin
                            n_sw_mode = gdwc_pkg::SW_CLEAR;
                            n_sweep   = '0;
                            n_state   = gdwc_pkg::S_SWEEP;
                        end
                        default: begin
                            fin = 1'b1; fin_status = gdwc_pkg::STS_RANGE;
                        end
                    endcase
                end
            end
            gdwc_pkg::S_LD_EDGE: begin
                // push on the front of the parent's edge list
                edge_we  = 1'b1;
                edge_wd  = {RW'(r_item.child_id), r_item.freq, ehead_rd};
                ehead_we = 1'b1;
                ehead_wa = RW'(r_item.parent_rule);
                ehead_wd = r_edge_fill + EPW'(1);
                etot_we  = 1'b1;
                etot_wa  = RW'(r_item.child_id);
                etot_wd  = etot_rd + EPW'(1);
                n_edge_fill = r_edge_fill + EPW'(1);
                fin = 1'b1;
            end
            gdwc_pkg::S_LD_OCC: begin
                occ_we   = 1'b1;
                occ_wd   = {WIW'(r_item.child_id), r_item.freq, ohead_rd};
                ohead_we = 1'b1;
                ohead_wa = RW'(r_item.parent_rule);
                ohead_wd = r_occ_fill + OPW'(1);
                n_occ_fill = r_occ_fill + OPW'(1);
                fin = 1'b1;
            end
            gdwc_pkg::S_QUERY: begin
                fin        = 1'b1;
                fin_status = run_status;
                fin_total  = gdwc_pkg::TOTAL_W'(word_rd);
            end
            gdwc_pkg::S_R_INIT: begin
                weight_we = 1'b1;
                weight_wa = '0;
                weight_wd = CW'(1);
                queue_we  = 1'b1;
                queue_wa  = '0;
                queue_wd  = '0;
                n_qhead   = '0;
                n_qtail   = QCW'(1);
                n_state   = gdwc_pkg::S_R_POP;
            end
            gdwc_pkg::S_R_POP: begin
                if (r_qhead == r_qtail) begin
                    n_rule  = '0;
                    n_state = gdwc_pkg::S_O_RULE;
                end else begin
                    n_qhead = r_qhead + QCW'(1);
                    n_state = gdwc_pkg::S_R_POP1;
                end
            end
            gdwc_pkg::S_R_POP1: begin
                n_cur    = queue_rd;
                ehead_ra = queue_rd;
                n_state  = gdwc_pkg::S_R_EHEAD;
            end
            gdwc_pkg::S_R_EHEAD: begin
                n_eptr  = ehead_rd;
                n_state = gdwc_pkg::S_R_EDGE;
            end
            gdwc_pkg::S_R_EDGE: begin
                if (r_eptr == '0) begin
                    n_state = gdwc_pkg::S_R_POP;
                end else begin
                    // weight re-read per edge: a self edge may have changed it
                    weight_ra = r_cur;
                    n_state   = gdwc_pkg::S_R_EDGE1;
                end
            end
            gdwc_pkg::S_R_EDGE1: begin
                {n_child, n_rep, n_eptr} = edge_rd;
                n_mul_a   = weight_rd;
                n_acc_occ = 1'b0;
                n_state   = gdwc_pkg::S_MUL0;
            end
            gdwc_pkg::S_O_RULE: begin
                if (r_rule == eff_rules) begin
                    fin        = 1'b1;
                    fin_status = run_status;
                end else begin
                    ohead_ra  = r_rule[RW-1:0];
                    weight_ra = r_rule[RW-1:0];
                    n_state   = gdwc_pkg::S_O_RULE1;
                end
            end
            gdwc_pkg::S_O_RULE1: begin
                n_optr  = ohead_rd;
                n_rw    = weight_rd;
                n_rule  = r_rule + RCW'(1);
                n_state = gdwc_pkg::S_O_WALK;
            end
            gdwc_pkg::S_O_WALK: begin
                if (r_optr == '0) begin
                    n_state = gdwc_pkg::S_O_RULE;
                end else begin
                    n_state = gdwc_pkg::S_O_WALK1;
                end
            end
            gdwc_pkg::S_O_WALK1: begin
                {n_word, n_rep, n_optr} = occ_rd;
                n_mul_a   = r_rw;
                n_acc_occ = 1'b1;
                n_state   = gdwc_pkg::S_MUL0;
            end
            gdwc_pkg::S_MUL0: begin
                n_plo   = mul_p;
                n_state = gdwc_pkg::S_MUL1;
            end
            gdwc_pkg::S_MUL1: begin
                n_phi   = mul_p;
                n_state = gdwc_pkg::S_MUL2;
            end
            gdwc_pkg::S_MUL2: begin
                if (prod_ovf) begin
                    n_prod = CNT_MAX;
                    n_sat  = 1'b1;
                end else begin
                    n_prod = prod_full[CW-1:0];
                end
                weight_ra = r_child;
                word_ra   = r_word;
                n_state   = gdwc_pkg::S_ACC;
            end
            gdwc_pkg::S_ACC: begin
                if (acc_sum[CW]) begin
                    n_sat = 1'b1;
                end
                if (r_acc_occ) begin
                    word_we = 1'b1;
                    word_wd = acc_sum[CW] ? CNT_MAX : acc_sum[CW-1:0];
                    n_state = gdwc_pkg::S_O_WALK;
                end else begin
                    weight_we = 1'b1;
                    weight_wd = acc_sum[CW] ? CNT_MAX : acc_sum[CW-1:0];
                    eseen_we  = 1'b1;
                    eseen_wd  = seen_inc;
                    if (seen_inc == etot_rd && 32'(r_qtail) < 32'(QN)) begin
                        queue_we = 1'b1;
                        n_qtail  = r_qtail + QCW'(1);
                    end
                    n_state = gdwc_pkg::S_R_EDGE;
                end
            end
            default: begin
                n_state = gdwc_pkg::S_IDLE;
            end
        endcase

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (fin) begin
            n_out_valid           = 1'b1;
            n_out_item.status     = fin_status;
            n_out_item.word_total = fin_total;
            n_state               = gdwc_pkg::S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdwc_pkg::S_SWEEP;
            r_sw_mode   <= gdwc_pkg::SW_RESET;
            r_sweep     <= '0;
            r_edge_fill <= '0;
            r_occ_fill  <= '0;
            r_sat       <= 1'b0;
            r_qhead     <= '0;
            r_qtail     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sw_mode   <= n_sw_mode;
            r_sweep     <= n_sweep;
            r_edge_fill <= n_edge_fill;
            r_occ_fill  <= n_occ_fill;
            r_sat       <= n_sat;
            r_qhead     <= n_qhead;
            r_qtail     <= n_qtail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_item <= n_out_item;
        r_cur      <= n_cur;
        r_child    <= n_child;
        r_word     <= n_word;
        r_rep      <= n_rep;
        r_eptr     <= n_eptr;
        r_optr     <= n_optr;
        r_rule     <= n_rule;
        r_rw       <= n_rw;
        r_mul_a    <= n_mul_a;
        r_plo      <= n_plo;
        r_phi      <= n_phi;
        r_prod     <= n_prod;
        r_acc_occ  <= n_acc_occ;
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_words <= gdwc_pkg::RST_NUM_WORDS;
            r_num_rules <= gdwc_pkg::RST_NUM_RULES;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gdwc_pkg::CFG_NUM_WORDS) begin
                r_num_words <= i_cfg_data[gdwc_pkg::NUM_WORDS_W-1:0];
            end else if (i_cfg_index == gdwc_pkg::CFG_NUM_RULES) begin
                r_num_rules <= i_cfg_data[gdwc_pkg::NUM_RULES_W-1:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_qhead) <= 32'(r_qtail))
        else $error("ready queue head passed tail");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_fill) <= 32'(MAX_EDGES) && 32'(r_occ_fill) <= 32'(MAX_OCCURRENCES))
        else $error("store fill beyond capacity");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item taken while another is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("pending result overwritten");

endmodule
